/* hdl/rht_pkg.sv */
// rht_pkg: shared types, constants and codes for the pointer registry hash table
// used by rht_hash, rht_ram users and pointer_registry_hash_table; no dependencies
`timescale 1ns / 1ps

package rht_pkg;

  localparam int CAPACITY = 1024;
  localparam int SLOT_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int HBITS    = $clog2(CAPACITY + 1) - 1;

  localparam logic [31:0] GOLDEN_LO = 32'h7f4a7c15;
  localparam logic [31:0] GOLDEN_HI = 32'h9e3779b9;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_LOOKUP = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_MISS = 2'd2;

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [63:0] key;
    logic [31:0] entry_bytes;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [10:0] slot_index;
    logic [31:0] found_bytes;
    logic [9:0]  live_count;
    logic [41:0] live_bytes;
  } out_item_t;

  typedef struct packed {
    logic [63:0] key;
    logic [31:0] entry_bytes;
  } entry_t;

  typedef struct packed {
    logic  done;
    slot_t slot;
  } hash_rsp_t;

endpackage

/* hdl/pointer_registry_hash_table.sv */
// pointer_registry_hash_table: open-addressed registry of live allocations
// depends on rht_pkg, rht_hash and rht_ram
//
// usage
//   in channel (in_valid / in_stall / in_data): one transaction per request,
//   op insert, remove or lookup with a 64-bit key and a 32-bit size
//   out channel (out_valid / out_stall / out_data): exactly one transaction per
//   request, with status, slot, stored size and the totals after the request
//   one request is worked on at a time; in_stall is high while it is busy
//   a request with key zero, an unused op, or an insert into a table holding
//   1023 entries answers without hashing and without touching the table
//   other requests take a hash then a linear probe reading one slot
//   per cycle from the entry memory, visiting n slots (n from 1 to 1024);
//   the single memory read port sets this pace
//   a result waits in the output register while out_stall is high; the next
//   request is already accepted and worked on, and holds only at its end
//   reset: after rst_n rises a clearing pass writes all 1024 slots to empty,
//   with in_stall high until it ends; totals restart at zero
`timescale 1ns / 1ps

module pointer_registry_hash_table (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  rht_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output rht_pkg::out_item_t out_data
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_HASH  = 3'd2;
  localparam logic [2:0] S_PROBE = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]          state_r, state_nxt;
  rht_pkg::slot_t      clr_addr_r, clr_addr_nxt;
  rht_pkg::in_item_t   req_r, req_nxt;
  logic [63:0]         want_r, want_nxt;
  rht_pkg::slot_t      probe_addr_r, probe_addr_nxt;
  rht_pkg::cnt_t       issue_cnt_r, issue_cnt_nxt;
  logic                pend_valid_r, pend_valid_nxt;
  rht_pkg::slot_t      pend_slot_r, pend_slot_nxt;
  logic [1:0]          res_status_r, res_status_nxt;
  logic [10:0]         res_slot_r, res_slot_nxt;
  logic [31:0]         res_found_r, res_found_nxt;
  logic [9:0]          count_r, count_nxt;
  logic [42:0]         total_r, total_nxt;
  logic                out_valid_r, out_valid_nxt;
  rht_pkg::out_item_t  out_r, out_nxt;

  logic                in_accept;
  logic                in_bad;
  logic                in_full;
  logic                hash_start;
  rht_pkg::hash_rsp_t  hash_rsp;
  logic                rd_en;
  rht_pkg::entry_t     rd_data;
  logic                hit;
  logic                out_free;
  logic                wr_en;
  rht_pkg::slot_t      wr_addr;
  rht_pkg::entry_t     wr_data;

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign in_bad    = (in_data.key == 64'd0) ||
                     ((in_data.op != rht_pkg::OP_INSERT) &&
                      (in_data.op != rht_pkg::OP_REMOVE) &&
                      (in_data.op != rht_pkg::OP_LOOKUP));
  assign in_full   = (in_data.op == rht_pkg::OP_INSERT) &&
                     (32'(count_r) >= 32'(rht_pkg::CAPACITY - 1));
  assign hash_start = in_accept && !in_bad && !in_full;

  assign rd_en    = (state_r == S_PROBE) &&
                    (issue_cnt_r != rht_pkg::cnt_t'(rht_pkg::CAPACITY));
  assign hit      = pend_valid_r && (rd_data.key == want_r);
  assign out_free = !out_valid_r || !out_stall;

  // write port: clearing pass, or the entry found by an insert or remove
  assign wr_en   = (state_r == S_CLEAR) ||
                   ((state_r == S_PROBE) && hit && (req_r.op != rht_pkg::OP_LOOKUP));
  assign wr_addr = (state_r == S_CLEAR) ? clr_addr_r : pend_slot_r;
  always_comb begin
    wr_data = '0;
    if ((state_r == S_PROBE) && (req_r.op == rht_pkg::OP_INSERT)) begin
      wr_data.key         = req_r.key;
      wr_data.entry_bytes = req_r.entry_bytes;
    end
  end

  rht_hash u_hash (
    .clk   (clk),
    .rst_n (rst_n),
    .start (hash_start),
    .key   (in_data.key),
    .rsp   (hash_rsp)
  );

  rht_ram #(
    .WIDTH ($bits(rht_pkg::entry_t)),
    .DEPTH (rht_pkg::CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (probe_addr_r),
    .rd_data (rd_data)
  );

  always_comb begin
    state_nxt      = state_r;
    clr_addr_nxt   = clr_addr_r;
    req_nxt        = req_r;
    want_nxt       = want_r;
    probe_addr_nxt = probe_addr_r;
    issue_cnt_nxt  = issue_cnt_r;
    pend_valid_nxt = pend_valid_r;
    pend_slot_nxt  = pend_slot_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    res_found_nxt  = res_found_r;
    count_nxt      = count_r;
    total_nxt      = total_r;
    out_valid_nxt  = out_valid_r;
    out_nxt        = out_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_CLEAR: begin
        if (clr_addr_r == rht_pkg::slot_t'(rht_pkg::CAPACITY - 1)) begin
          clr_addr_nxt = '0;
          state_nxt    = S_IDLE;
        end else begin
          clr_addr_nxt = clr_addr_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (in_accept) begin
          req_nxt  = in_data;
          want_nxt = (in_data.op == rht_pkg::OP_INSERT) ? 64'd0 : in_data.key;
          res_slot_nxt  = 11'(rht_pkg::CAPACITY);
          res_found_nxt = '0;
          if (in_bad) begin
            res_status_nxt = rht_pkg::ST_MISS;
            state_nxt      = S_DONE;
          end else if (in_full) begin
            res_status_nxt = rht_pkg::ST_FULL;
            state_nxt      = S_DONE;
          end else begin
            state_nxt = S_HASH;
          end
        end
      end
      S_HASH: begin
        if (hash_rsp.done) begin
          probe_addr_nxt = hash_rsp.slot;
          issue_cnt_nxt  = '0;
          pend_valid_nxt = 1'b0;
          state_nxt      = S_PROBE;
        end
      end
      S_PROBE: begin
        pend_valid_nxt = rd_en;
        pend_slot_nxt  = probe_addr_r;
        if (rd_en) begin
          issue_cnt_nxt  = issue_cnt_r + 1'b1;
          probe_addr_nxt = (probe_addr_r == rht_pkg::slot_t'(rht_pkg::CAPACITY - 1)) ?
                           '0 : probe_addr_r + 1'b1;
        end
        if (hit) begin
          res_status_nxt = rht_pkg::ST_OK;
          res_slot_nxt   = 11'(pend_slot_r);
          state_nxt      = S_DONE;
          case (req_r.op)
            rht_pkg::OP_INSERT: begin
              res_found_nxt = '0;
              count_nxt     = count_r + 1'b1;
              total_nxt     = total_r + 43'(req_r.entry_bytes);
            end
            rht_pkg::OP_REMOVE: begin
              res_found_nxt = rd_data.entry_bytes;
              count_nxt     = count_r - 1'b1;
              total_nxt     = total_r - 43'(rd_data.entry_bytes);
            end
            default: begin
              res_found_nxt = rd_data.entry_bytes;
            end
          endcase
        end else if (pend_valid_r && !rd_en) begin
          res_status_nxt = (req_r.op == rht_pkg::OP_INSERT) ?
                           rht_pkg::ST_FULL : rht_pkg::ST_MISS;
          res_slot_nxt   = 11'(rht_pkg::CAPACITY);
          res_found_nxt  = '0;
          state_nxt      = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt       = 1'b1;
          out_nxt.status      = res_status_r;
          out_nxt.slot_index  = res_slot_r;
          out_nxt.found_bytes = res_found_r;
          out_nxt.live_count  = count_r;
          out_nxt.live_bytes  = total_r[41:0];
          state_nxt           = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_addr_r   <= '0;
      issue_cnt_r  <= '0;
      pend_valid_r <= 1'b0;
      count_r      <= '0;
      total_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_addr_r   <= clr_addr_nxt;
      issue_cnt_r  <= issue_cnt_nxt;
      pend_valid_r <= pend_valid_nxt;
      count_r      <= count_nxt;
      total_r      <= total_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r        <= req_nxt;
    want_r       <= want_nxt;
    probe_addr_r <= probe_addr_nxt;
    pend_slot_r  <= pend_slot_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    res_found_r  <= res_found_nxt;
    out_r        <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // no transaction in or out during the clearing pass
  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> (in_stall && !out_valid_r))
    else $error("transaction during clearing pass");

  // the hash unit only answers a request that is waiting for it
  a_hash_owned: assert property (@(posedge clk) disable iff (!rst_n)
    hash_rsp.done |-> (state_r == S_HASH))
    else $error("hash result with no request waiting");

  // memory writes only from the clearing pass or a probe hit
  a_write_src: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> ((state_r == S_CLEAR) || ((state_r == S_PROBE) && hit)))
    else $error("unexpected entry memory write");

  // an exhausted probe always ends the request
  a_probe_ends: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_PROBE) && pend_valid_r && !rd_en) |=> (state_r == S_DONE))
    else $error("probe ran past the last slot");

endmodule

/* hdl/rht_ram.sv */
// rht_ram: generic single-write, single-read memory with registered read data
// no dependencies
`timescale 1ns / 1ps

module rht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* hdl/rht_hash.sv */
// rht_hash: multi-cycle fibonacci hash giving the home slot of a key
// one shared 32x32 multiplier over three partial products; depends on rht_pkg
`timescale 1ns / 1ps

module rht_hash (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [63:0]        key,
  output rht_pkg::hash_rsp_t rsp
);

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_LL   = 3'd1;
  localparam logic [2:0] PH_LH   = 3'd2;
  localparam logic [2:0] PH_HL   = 3'd3;
  localparam logic [2:0] PH_SUM  = 3'd4;

  logic [2:0]  phase_r, phase_nxt;
  logic        done_r, done_nxt;
  logic [60:0] a_r, a_nxt;
  logic [63:0] prod_r, prod_nxt;
  logic [31:0] low_hi_r, low_hi_nxt;
  logic [31:0] cross_r, cross_nxt;
  rht_pkg::slot_t slot_r, slot_nxt;

  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] mul_p;
  logic [31:0] h_hi;
  logic [rht_pkg::HBITS-1:0] top_bits;

  always_comb begin
    case (phase_r)
      PH_LL: begin
        mul_a = a_r[31:0];
        mul_b = rht_pkg::GOLDEN_LO;
      end
      PH_LH: begin
        mul_a = a_r[31:0];
        mul_b = rht_pkg::GOLDEN_HI;
      end
      PH_HL: begin
        mul_a = {3'b000, a_r[60:32]};
        mul_b = rht_pkg::GOLDEN_LO;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p    = 64'(mul_a) * 64'(mul_b);
  assign h_hi     = low_hi_r + cross_r + prod_r[31:0];
  assign top_bits = h_hi[31 -: rht_pkg::HBITS];

  always_comb begin
    phase_nxt  = phase_r;
    done_nxt   = 1'b0;
    a_nxt      = a_r;
    prod_nxt   = prod_r;
    low_hi_nxt = low_hi_r;
    cross_nxt  = cross_r;
    slot_nxt   = slot_r;
    case (phase_r)
      PH_IDLE: begin
        if (start) begin
          a_nxt     = key[63:3];
          phase_nxt = PH_LL;
        end
      end
      PH_LL: begin
        prod_nxt  = mul_p;
        phase_nxt = PH_LH;
      end
      PH_LH: begin
        low_hi_nxt = prod_r[63:32];
        prod_nxt   = mul_p;
        phase_nxt  = PH_HL;
      end
      PH_HL: begin
        cross_nxt = prod_r[31:0];
        prod_nxt  = mul_p;
        phase_nxt = PH_SUM;
      end
      PH_SUM: begin
        slot_nxt  = (32'(top_bits) < 32'(rht_pkg::CAPACITY)) ?
                    rht_pkg::slot_t'(top_bits) : '0;
        done_nxt  = 1'b1;
        phase_nxt = PH_IDLE;
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      done_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r      <= a_nxt;
    prod_r   <= prod_nxt;
    low_hi_r <= low_hi_nxt;
    cross_r  <= cross_nxt;
    slot_r   <= slot_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.slot = slot_r;

endmodule

/* verif/pointer_registry_checker.sv */
// pointer_registry_checker: watches the request and result channels of the registry,
// keeps its own copy of the table and totals, and compares every result field by field
// depends on rht_pkg
`timescale 1ns / 1ps

module pointer_registry_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  rht_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  rht_pkg::out_item_t out_data,
  output int                 fail_count,
  output int                 outstanding,
  output int                 results_seen
);
  import rht_pkg::*;

  localparam logic [63:0] GOLDEN = {GOLDEN_HI, GOLDEN_LO};

  logic [63:0] reg_keys  [CAPACITY];
  logic [31:0] reg_sizes [CAPACITY];
  logic [9:0]  reg_count;
  logic [42:0] reg_bytes;
  out_item_t   result_q [$];
  out_item_t   oldest;

  initial begin
    fail_count   = 0;
    outstanding  = 0;
    results_seen = 0;
  end

  function automatic int home_slot_of(logic [63:0] key);
    logic [63:0] h;
    h = (key >> 3) * GOLDEN;
    return int'(h >> (64 - HBITS));
  endfunction

  // first slot in probe order holding want, CAPACITY when none
  function automatic int probe_for(int start, logic [63:0] want);
    int idx;
    idx = start;
    for (int n = 0; n < CAPACITY; n++) begin
      if (reg_keys[idx] == want) return idx;
      idx = (idx + 1) % CAPACITY;
    end
    return CAPACITY;
  endfunction

  function automatic out_item_t apply_request(in_item_t req);
    out_item_t res;
    int        idx;
    res.status      = ST_MISS;
    res.slot_index  = 11'(CAPACITY);
    res.found_bytes = '0;
    if (req.key != '0 && req.op <= OP_LOOKUP) begin
      if (req.op == OP_INSERT) begin
        if (int'(reg_count) >= CAPACITY - 1) begin
          res.status = ST_FULL;
        end else begin
          idx = probe_for(home_slot_of(req.key), '0);
          if (idx < CAPACITY) begin
            reg_keys[idx]  = req.key;
            reg_sizes[idx] = req.entry_bytes;
            reg_count      = reg_count + 10'd1;
            reg_bytes      = reg_bytes + 43'(req.entry_bytes);
            res.status     = ST_OK;
            res.slot_index = 11'(idx);
          end else begin
            res.status = ST_FULL;
          end
        end
      end else begin
        idx = probe_for(home_slot_of(req.key), req.key);
        if (idx < CAPACITY) begin
          res.status      = ST_OK;
          res.slot_index  = 11'(idx);
          res.found_bytes = reg_sizes[idx];
          if (req.op == OP_REMOVE) begin
            reg_count      = reg_count - 10'd1;
            reg_bytes      = reg_bytes - 43'(reg_sizes[idx]);
            reg_keys[idx]  = '0;
            reg_sizes[idx] = '0;
          end
        end
      end
    end
    res.live_count = reg_count;
    res.live_bytes = reg_bytes[41:0];
    return res;
  endfunction

  task automatic check_field(string field, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CAPACITY; i++) begin
        reg_keys[i]  = '0;
        reg_sizes[i] = '0;
      end
      reg_count = '0;
      reg_bytes = '0;
      result_q.delete();
      outstanding = 0;
    end else begin
      // older transaction first: a result never belongs to a request taken at the same edge
      if (out_valid && !out_stall) begin
        results_seen++;
        if (result_q.size() == 0) begin
          $error("result with no request outstanding: 0x%0h", out_data);
          fail_count++;
        end else begin
          oldest = result_q.pop_front();
          outstanding--;
          check_field("status", oldest.status, out_data.status);
          check_field("slot_index", oldest.slot_index, out_data.slot_index);
          check_field("found_bytes", oldest.found_bytes, out_data.found_bytes);
          check_field("live_count", oldest.live_count, out_data.live_count);
          check_field("live_bytes", oldest.live_bytes, out_data.live_bytes);
        end
      end
      if (in_valid && !in_stall) begin
        result_q.push_back(apply_request(in_data));
        outstanding++;
      end
    end
  end

endmodule

/* verif/tb_pointer_registry_hash_table.sv */
// tb_pointer_registry_hash_table: clock, reset, request stimulus and result back-pressure
// for the pointer registry; checking is done by pointer_registry_checker
// depends on rht_pkg, pointer_registry_hash_table and pointer_registry_checker
`timescale 1ns / 1ps

module tb_pointer_registry_hash_table;
  import rht_pkg::*;

  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam int         CYCLE_LIMIT = 8_000_000;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      out_stall = 1'b0;
  in_item_t  in_data   = '0;
  logic      in_stall;
  logic      out_valid;
  out_item_t out_data;

  int fail_count;
  int outstanding;
  int results_seen;
  int cycles      = 0;
  int sent_total  = 0;
  int sent_insert = 0;
  int sent_remove = 0;
  int sent_lookup = 0;
  int sent_odd    = 0;
  bit steady      = 1'b0;

  logic [63:0] live_keys [$];
  logic [63:0] cluster_base [6];

  always #5 clk = ~clk;

  pointer_registry_hash_table u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  pointer_registry_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .fail_count  (fail_count),
    .outstanding (outstanding),
    .results_seen(results_seen)
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // result side back-pressure, with two long hold-offs that fill the block
  initial begin : result_sink
    int stall_left;
    int taken;
    bit quiet;
    stall_left = 0;
    taken      = 0;
    quiet      = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        taken++;
        if (taken % 64 == 0) quiet = ($urandom_range(0, 2) == 0);
        if (taken == 150 || taken == 450) stall_left = 400;
        else stall_left = quiet ? 0 : $urandom_range(0, 5);
      end
      @(negedge clk);
      out_stall <= (stall_left > 0);
      if (stall_left > 0) stall_left--;
    end
  end

  task automatic send(logic [1:0] op, logic [63:0] key, logic [31:0] bytes);
    int gap;
    if (sent_total % 40 == 0) steady = ($urandom_range(0, 3) == 0);
    gap = steady ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= {op, key, bytes};
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    sent_total++;
    if (key == '0 || op == OP_UNUSED) sent_odd++;
    else if (op == OP_INSERT) sent_insert++;
    else if (op == OP_REMOVE) sent_remove++;
    else sent_lookup++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
  endtask

  function automatic logic [63:0] any_key();
    logic [63:0] k;
    k = {$urandom, $urandom};
    if (k == '0) k = 64'h8;
    return k;
  endfunction

  // keys differing only in the low three bits share a home slot
  function automatic logic [63:0] clustered_key();
    return cluster_base[$urandom_range(0, 5)] | 64'($urandom_range(0, 7));
  endfunction

  function automatic logic [63:0] pick_live(bit take);
    int          i;
    logic [63:0] k;
    if (live_keys.size() == 0) return any_key();
    i = $urandom_range(0, live_keys.size() - 1);
    k = live_keys[i];
    if (take) live_keys.delete(i);
    return k;
  endfunction

  function automatic logic [31:0] size_draw();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 32'h0;
    if (r == 1) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  task automatic random_request();
    int          r;
    logic [63:0] k;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      k = (r < 20) ? clustered_key() : (r < 40) ? any_key() : pick_live(1'b0);
      live_keys.push_back(k);
      send(OP_INSERT, k, size_draw());
    end else if (r < 65) begin
      send(OP_LOOKUP, pick_live(1'b0), $urandom);
    end else if (r < 85) begin
      send(OP_REMOVE, pick_live(1'b1), $urandom);
    end else if (r < 93) begin
      send(r[0] ? OP_REMOVE : OP_LOOKUP, any_key(), $urandom);
    end else if (r < 97) begin
      send(2'($urandom_range(0, 3)), '0, $urandom);
    end else begin
      send(OP_UNUSED, any_key(), $urandom);
    end
  endtask

  initial begin : stimulus
    logic [63:0] ka;
    logic [63:0] kb;
    for (int i = 0; i < 6; i++) cluster_base[i] = ({$urandom, $urandom} & ~64'h7) | 64'h8;
    ka = cluster_base[0];
    kb = cluster_base[0] | 64'h7;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty table, duplicates, shared home slot, extremes, zero key, unused op
    send(OP_LOOKUP, ka, 32'h0);
    send(OP_INSERT, ka, 32'hFFFF_FFFF);
    send(OP_INSERT, ka, 32'h0);
    send(OP_INSERT, kb, 32'h1);
    send(OP_LOOKUP, ka, 32'h0);
    send(OP_REMOVE, ka, 32'h0);
    send(OP_LOOKUP, ka, 32'h0);
    send(OP_LOOKUP, kb, 32'h0);
    send(OP_REMOVE, kb, 32'h0);
    send(OP_REMOVE, kb, 32'h0);
    send(OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 32'h8000_0000);
    send(OP_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0);
    send(OP_INSERT, 64'h1, 32'h1234_5678);
    send(OP_INSERT, 64'h8, 32'hFFFF_FFFF);
    send(OP_INSERT, '0, 32'hFFFF_FFFF);
    send(OP_REMOVE, '0, 32'h0);
    send(OP_LOOKUP, '0, 32'h0);
    send(OP_UNUSED, '0, 32'h0);
    send(OP_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
    send(OP_REMOVE, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0);
    send(OP_REMOVE, ka, 32'h0);
    send(OP_REMOVE, 64'h1, 32'h0);
    live_keys.push_back(64'h8);
    drain();

    // mixed traffic in rounds, sender pausing for all results between rounds
    repeat (8) begin
      repeat (70) random_request();
      drain();
    end

    repeat (50) @(posedge clk);
    $display("requests sent: %0d (%0d insert, %0d remove, %0d lookup, %0d zero key or unused op)",
             sent_total, sent_insert, sent_remove, sent_lookup, sent_odd);
    $display("results checked: %0d; shared home slots, long result hold-offs and idle drains",
             results_seen);
    if (fail_count == 0 && outstanding == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/rht_pkg.sv
hdl/rht_ram.sv
hdl/rht_hash.sv
hdl/pointer_registry_hash_table.sv
verif/pointer_registry_checker.sv
verif/tb_pointer_registry_hash_table.sv
